### sv/dynamic_priority_process_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_PRIORITY_PROCESS_SCHEDULER_DEFINES_SVH
`define DYNAMIC_PRIORITY_PROCESS_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

`define DPPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

`define DPPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`else

`define DPPS_ASSERT_SAME(lbl, ante, cons)

`define DPPS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/dpps_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Types and codes shared by the scheduler modules.
// ----------------------------------------------------------------------------
package dpps_pkg;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    STAT_ADDED = 3'd0,
    STAT_FULL  = 3'd1,
    STAT_ZERO  = 3'd2,
    STAT_RAN   = 3'd3,
    STAT_IDLE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_WRITE
  } fsm_t;

  typedef struct packed {
    logic [7:0]  pid;
    logic [15:0] run_left;
    logic [7:0]  prio;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } sel_ctl_t;

endpackage

### sv/dynamic_priority_process_scheduler.sv
// ----------------------------------------------------------------------------
// Dynamic priority process scheduler
// Process table with highest-priority selection; each tick runs the selected process and lowers its priority.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  request   start / busy       in_cmd, in_proc_id, in_run_time, in_start_priority
//  result    out_valid strobe   out_status, out_ran_id, out_time_left,
//                               out_priority_now, out_finished
//
// An add request or a tick on an empty table gives its result in the next cycle.
// A tick reads the table memory one slot per cycle; it passes through the scan,
// a drain state for the read latency, a write-back state and the result
// register.
// Synchronous reset clears the slot valid bits and the controller.
// The result strobe lasts one cycle and the receiver cannot hold it off; busy
// is high while a tick is in progress.
// ----------------------------------------------------------------------------
`include "dynamic_priority_process_scheduler_defines.svh"

module dynamic_priority_process_scheduler #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [7:0]  in_proc_id,
  input  logic [15:0] in_run_time,
  input  logic [7:0]  in_start_priority,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_ran_id,
  output logic [15:0] out_time_left,
  output logic [7:0]  out_priority_now,
  output logic        out_finished
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

  dpps_pkg::fsm_t     state_r, state_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic               rd_pend_r;
  logic [AW-1:0]      rd_idx_r;
  logic               accept;
  logic               free_found;
  logic [AW-1:0]      free_idx;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  dpps_pkg::entry_t   mem_wdata;
  logic               mem_re;
  dpps_pkg::entry_t   mem_rdata;

  dpps_pkg::sel_ctl_t sel_ctl;
  logic               sel_have;
  logic [AW-1:0]      sel_idx;
  dpps_pkg::entry_t   sel_best;

  logic [15:0]        new_time;
  logic [7:0]         new_prio;
  logic               new_fin;

  logic               out_valid_r, out_valid_nxt;
  dpps_pkg::status_t  out_status_r, out_status_nxt;
  logic [7:0]         out_ran_id_r, out_ran_id_nxt;
  logic [15:0]        out_time_left_r, out_time_left_nxt;
  logic [7:0]         out_priority_now_r, out_priority_now_nxt;
  logic               out_finished_r, out_finished_nxt;

  assign busy   = (state_r != dpps_pkg::FSM_IDLE);
  assign accept = start && !busy;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        free_found = 1'b1;
        free_idx   = AW'(k);
      end
    end
  end

  dpps_mem #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cnt_r),
    .rdata (mem_rdata)
  );

  dpps_sel #(
    .AW (AW)
  ) u_sel (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (sel_ctl),
    .rd_idx        (rd_idx_r),
    .rd_slot_valid (valid_r[rd_idx_r]),
    .rd_data       (mem_rdata),
    .have          (sel_have),
    .best_idx      (sel_idx),
    .best          (sel_best)
  );

  assign new_time = sel_best.run_left - 16'd1;
  assign new_prio = (sel_best.prio == 8'd0) ? 8'd0 : (sel_best.prio - 8'd1);
  assign new_fin  = (new_time == 16'd0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dpps_pkg::FSM_IDLE: begin
        if (accept && (in_cmd == dpps_pkg::CMD_TICK) && (|valid_r)) begin
          state_nxt = dpps_pkg::FSM_SCAN;
        end
      end
      dpps_pkg::FSM_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = dpps_pkg::FSM_DRAIN;
        end
      end
      dpps_pkg::FSM_DRAIN: begin
        state_nxt = dpps_pkg::FSM_WRITE;
      end
      dpps_pkg::FSM_WRITE: begin
        state_nxt = dpps_pkg::FSM_IDLE;
      end
      default: begin
        state_nxt = dpps_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_nxt            = valid_r;
    cnt_nxt              = '0;
    mem_we               = 1'b0;
    mem_waddr            = free_idx;
    mem_wdata            = '{pid: in_proc_id, run_left: in_run_time, prio: in_start_priority};
    mem_re               = 1'b0;
    sel_ctl              = '{clear: accept, sample: rd_pend_r};
    out_valid_nxt        = 1'b0;
    out_status_nxt       = dpps_pkg::STAT_IDLE;
    out_ran_id_nxt       = '0;
    out_time_left_nxt    = '0;
    out_priority_now_nxt = '0;
    out_finished_nxt     = 1'b0;
    unique case (state_r)
      dpps_pkg::FSM_IDLE: begin
        if (accept) begin
          if (in_cmd == dpps_pkg::CMD_ADD) begin
            out_valid_nxt = 1'b1;
            if (in_run_time == 16'd0) begin
              out_status_nxt = dpps_pkg::STAT_ZERO;
            end else if (!free_found) begin
              out_status_nxt = dpps_pkg::STAT_FULL;
            end else begin
              out_status_nxt      = dpps_pkg::STAT_ADDED;
              mem_we              = 1'b1;
              valid_nxt[free_idx] = 1'b1;
            end
          end else if (!(|valid_r)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = dpps_pkg::STAT_IDLE;
          end
        end
      end
      dpps_pkg::FSM_SCAN: begin
        mem_re  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
      dpps_pkg::FSM_DRAIN: begin
        cnt_nxt = '0;
      end
      dpps_pkg::FSM_WRITE: begin
        mem_we               = 1'b1;
        mem_waddr            = sel_idx;
        mem_wdata            = '{pid: sel_best.pid, run_left: new_time, prio: new_prio};
        valid_nxt[sel_idx]   = !new_fin;
        out_valid_nxt        = 1'b1;
        out_status_nxt       = dpps_pkg::STAT_RAN;
        out_ran_id_nxt       = sel_best.pid;
        out_time_left_nxt    = new_time;
        out_priority_now_nxt = new_prio;
        out_finished_nxt     = new_fin;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpps_pkg::FSM_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= mem_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (out_valid_nxt) begin
      out_status_r       <= out_status_nxt;
      out_ran_id_r       <= out_ran_id_nxt;
      out_time_left_r    <= out_time_left_nxt;
      out_priority_now_r <= out_priority_now_nxt;
      out_finished_r     <= out_finished_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_ran_id       = out_ran_id_r;
  assign out_time_left    = out_time_left_r;
  assign out_priority_now = out_priority_now_r;
  assign out_finished     = out_finished_r;

  `DPPS_ASSERT_SAME(a_result_when_idle, out_valid_r, state_r == dpps_pkg::FSM_IDLE)
  `DPPS_ASSERT_SAME(a_write_has_pick, state_r == dpps_pkg::FSM_WRITE, sel_have)
  `DPPS_ASSERT_SAME(a_add_fills_slot, out_valid_r && (out_status_r == dpps_pkg::STAT_ADDED), $countones(valid_r) == $countones($past(valid_r)) + 1)
  `DPPS_ASSERT_NEXT(a_tick_starts_scan, accept && (in_cmd == dpps_pkg::CMD_TICK) && (|valid_r), state_r == dpps_pkg::FSM_SCAN && cnt_r == '0)

endmodule

### sv/dpps_mem.sv
// ----------------------------------------------------------------------------
// Scheduler process table
// Single-port-write, single-port-read synchronous memory with registered data.
// ----------------------------------------------------------------------------
module dpps_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  dpps_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output dpps_pkg::entry_t rdata
);

  dpps_pkg::entry_t mem [DEPTH];
  dpps_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/dpps_sel.sv
// ----------------------------------------------------------------------------
// Scheduler selection tracker
// Keeps the best entry seen during a table scan; ties go to the lower slot.
// ----------------------------------------------------------------------------
module dpps_sel #(
  parameter int AW = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dpps_pkg::sel_ctl_t ctl,
  input  logic [AW-1:0]      rd_idx,
  input  logic               rd_slot_valid,
  input  dpps_pkg::entry_t   rd_data,
  output logic               have,
  output logic [AW-1:0]      best_idx,
  output dpps_pkg::entry_t   best
);

  logic             have_r, have_nxt;
  logic             take;
  logic [AW-1:0]    best_idx_r;
  dpps_pkg::entry_t best_r;

  always_comb begin
    take     = ctl.sample && rd_slot_valid && (!have_r || (rd_data.prio > best_r.prio));
    have_nxt = have_r;
    if (ctl.clear) begin
      have_nxt = 1'b0;
    end else if (take) begin
      have_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r <= rd_idx;
      best_r     <= rd_data;
    end
  end

  assign have     = have_r;
  assign best_idx = best_idx_r;
  assign best     = best_r;

endmodule
